// File: hdl/iss_pkg.sv
// Shared types and constants of the insertion sorter.
`default_nettype none
package iss_pkg;

	localparam int unsigned VALUE_W = 32;

	// Controller states
	typedef enum logic [0:0] {
		ST_FILL,
		ST_DRAIN
	} iss_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic insert;     // insert the input value into the cell chain
		logic drain_step; // shift the chain down by one after an output transfer
		logic run_done;   // the last value of the run leaves; clear the drop flag
	} iss_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic last_one;   // exactly one value remains in the chain
	} iss_sts_t;

endpackage
`default_nettype wire

// File: hdl/iss_ctrl.sv
// Controller state machine of the insertion sorter: fill phase and drain phase.
`default_nettype none
module iss_ctrl
	import iss_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     sample_valid,
	input  wire logic     set_end,
	output logic          sample_ready,
	output logic          result_valid,
	input  wire logic     result_ready,
	input  wire iss_sts_t sts,
	output iss_cmd_t      cmd
);

	iss_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		sample_ready = 1'b0;
		result_valid = 1'b0;
		cmd          = '0;
		case (state_q)
			ST_FILL: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					cmd.insert = 1'b1;
					if (set_end) begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				result_valid = 1'b1;
				if (result_ready) begin
					cmd.drain_step = 1'b1;
					if (sts.last_one) begin
						cmd.run_done = 1'b1;
						state_d      = ST_FILL;
					end
				end
			end
			default: begin
				state_d = ST_FILL;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: hdl/iss_datapath.sv
// Datapath of the insertion sorter: a chain of compare-and-shift cells with count and drop flag.
`default_nettype none
module iss_datapath
	import iss_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire iss_cmd_t                  cmd,
	input  wire logic signed [VALUE_W-1:0] sample_value,
	output logic signed [VALUE_W-1:0]      sorted_value,
	output logic                           run_end,
	output logic                           overflowed,
	output iss_sts_t                       sts
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic signed [VALUE_W-1:0] cell_q [DEPTH];
	logic [CNT_W-1:0]          count_q;
	logic                      drop_q;
	logic [DEPTH-1:0]          less;
	logic                      full;

	assign full = (count_q == CNT_W'(DEPTH));

	// Each occupied cell compares its value against the incoming one
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			less[i] = (CNT_W'(i) < count_q) && (cell_q[i] < sample_value);
		end
	end

	// Cells: keep, take the new value, or shift up on insert; shift down on drain
	always_ff @(posedge clk) begin
		if (cmd.insert && !full) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (!less[i]) begin
					if (i == 0) begin
						cell_q[i] <= sample_value;
					end else if (less[i-1]) begin
						cell_q[i] <= sample_value;
					end else begin
						cell_q[i] <= cell_q[i-1];
					end
				end
			end
		end else if (cmd.drain_step) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				cell_q[i] <= cell_q[i+1];
			end
		end
	end

	// Fill count and drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drop_q  <= 1'b0;
		end else begin
			if (cmd.insert) begin
				if (full) begin
					drop_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if (cmd.drain_step) begin
				count_q <= count_q - CNT_W'(1);
				if (cmd.run_done) begin
					drop_q <= 1'b0;
				end
			end
		end
	end

	assign sorted_value = cell_q[0];
	assign run_end      = (count_q == CNT_W'(1));
	assign overflowed   = drop_q;
	assign sts.last_one = run_end;

endmodule
`default_nettype wire

// File: hdl/insertion_sorter_unit.sv
// Insertion sorter top level: one value inserted per cycle, sorted run drained on set end.
// Fill: one input transfer per cycle into the compare-and-shift cell chain.
// Drain: first result is offered the cycle after the set_end transfer, then one per cycle
// while result_ready is high, DEPTH results at most; no input is taken while a run drains.
// Reset (arst_n low, asynchronous) empties the chain and clears the drop flag.
`default_nettype none
module insertion_sorter_unit
	import iss_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      sample_valid,
	output logic                           sample_ready,
	input  wire logic signed [VALUE_W-1:0] sample_value,
	input  wire logic                      set_end,
	output logic                           result_valid,
	input  wire logic                      result_ready,
	output logic signed [VALUE_W-1:0]      sorted_value,
	output logic                           run_end,
	output logic                           overflowed
);

	iss_cmd_t cmd;
	iss_sts_t sts;

	iss_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.set_end      (set_end),
		.sample_ready (sample_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	iss_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sample_value (sample_value),
		.sorted_value (sorted_value),
		.run_end      (run_end),
		.overflowed   (overflowed),
		.sts          (sts)
	);

endmodule
`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench of the insertion sorter: random sets, sorted-run prediction, stalls.
`timescale 1ns / 100ps
module tb_top;
	import iss_pkg::*;

	localparam int DEPTH      = 16;
	localparam int RAND_ITEMS = 405;
	localparam int LONG_HOLD  = 400;
	localparam int TAIL_WAIT  = 32;
	localparam int MAX_SHOWN  = 10;
	localparam longint TIMEOUT_NS = 2_000_000;

	localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
		bit                        sync; // hold until every pending run has drained
	} sample_item_t;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic                      run_end;
		logic                      overflowed;
	} sorted_item_t;

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      sample_valid = 1'b0;
	logic                      sample_ready;
	logic signed [VALUE_W-1:0] sample_value = '0;
	logic                      set_end      = 1'b0;
	logic                      result_valid;
	logic                      result_ready = 1'b0;
	logic signed [VALUE_W-1:0] sorted_value;
	logic                      run_end;
	logic                      overflowed;

	insertion_sorter_unit #(.DEPTH(DEPTH)) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_value (sample_value),
		.set_end      (set_end),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sorted_value (sorted_value),
		.run_end      (run_end),
		.overflowed   (overflowed)
	);

	// Pending stimulus and the sorted runs still owed by the block
	sample_item_t pending_q[$];
	sorted_item_t sorted_q[$];

	// Shadow copy of the sorter state
	logic signed [VALUE_W-1:0] shadow_store [DEPTH];
	int                        shadow_count = 0;
	bit                        shadow_drop  = 1'b0;

	int error_count   = 0;
	int items_taken   = 0;
	int results_seen  = 0;
	int runs_seen     = 0;
	int overflow_runs = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("FAILURE");
		$finish;
	end

	// Insert one accepted value; on set end queue the whole ascending run and clear
	task automatic sort_insert(input logic signed [VALUE_W-1:0] v, input logic last);
		int pos;
		sorted_item_t r;
		if (shadow_count >= DEPTH) begin
			shadow_drop = 1'b1;
		end else begin
			pos = 0;
			while (pos < shadow_count && shadow_store[pos] < v)
				pos++;
			for (int i = shadow_count; i > pos; i--)
				shadow_store[i] = shadow_store[i-1];
			shadow_store[pos] = v;
			shadow_count++;
		end
		if (last) begin
			for (int k = 0; k < shadow_count; k++) begin
				r.value      = shadow_store[k];
				r.run_end    = (k == shadow_count - 1);
				r.overflowed = shadow_drop;
				sorted_q.push_back(r);
			end
			if (shadow_drop)
				overflow_runs++;
			shadow_count = 0;
			shadow_drop  = 1'b0;
		end
	endtask

	task automatic queue_sample(input logic signed [VALUE_W-1:0] v, input logic last,
			input bit sync);
		sample_item_t it;
		it.value = v;
		it.last  = last;
		it.sync  = sync;
		pending_q.push_back(it);
	endtask

	// Mix of full-range, clustered (many ties) and extreme values
	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return $urandom;
			5, 6:          return $signed($urandom_range(0, 8)) - 4;
			7: begin
				case ($urandom_range(0, 3))
					0:       return VAL_MIN;
					1:       return VAL_MAX;
					2:       return '0;
					default: return -1;
				endcase
			end
			8:       return ($urandom_range(0, 1) ? VAL_MIN : VAL_MAX - 3) + $urandom_range(0, 3);
			default: return $signed($urandom_range(0, 255)) <<< $urandom_range(0, 24);
		endcase
	endfunction

	// Driver: bursts of transfers separated by random gaps
	int burst_left = 4;
	int gap_left   = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else begin
			if (sample_valid && sample_ready) begin
				sort_insert(sample_value, set_end);
				items_taken++;
			end
			if (!sample_valid || sample_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					sample_valid <= 1'b0;
				end else if (pending_q.size() != 0 &&
						!(pending_q[0].sync && sorted_q.size() != 0)) begin
					sample_valid <= 1'b1;
					sample_value <= pending_q[0].value;
					set_end      <= pending_q[0].last;
					void'(pending_q.pop_front());
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: readiness pattern chosen by the upper bits of a free-running tick, plus one long hold-off
	logic [8:0] stall_tick     = '0;
	int         hold_left      = 0;
	bit         long_hold_done = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			stall_tick <= stall_tick + 1'b1;
			if (hold_left > 0) begin
				hold_left    <= hold_left - 1;
				result_ready <= 1'b0;
			end else if (!long_hold_done && results_seen >= 40) begin
				hold_left      <= LONG_HOLD;
				long_hold_done <= 1'b1;
				result_ready   <= 1'b0;
			end else begin
				case (stall_tick[8:6])
					3'd0, 3'd6: result_ready <= 1'b1;
					3'd1, 3'd7: result_ready <= 1'($urandom_range(0, 1));
					3'd2:       result_ready <= (stall_tick[1:0] == 2'd0);
					3'd3:       result_ready <= ~stall_tick[2];
					3'd4:       result_ready <= ($urandom_range(0, 3) != 0);
					default:    result_ready <= stall_tick[0] ^ stall_tick[3];
				endcase
			end
		end
	end

	// Monitor: compare each result transfer with the oldest expected entry
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			results_seen++;
			if (sorted_q.size() == 0) begin
				if (error_count < MAX_SHOWN)
					$display("unexpected result: value=%0d run_end=%0b overflowed=%0b",
						sorted_value, run_end, overflowed);
				error_count++;
			end else begin
				if (sorted_value !== sorted_q[0].value || run_end !== sorted_q[0].run_end ||
						overflowed !== sorted_q[0].overflowed) begin
					if (error_count < MAX_SHOWN)
						$display("mismatch at result %0d: exp %0d/%0b/%0b got %0d/%0b/%0b",
							results_seen, sorted_q[0].value, sorted_q[0].run_end,
							sorted_q[0].overflowed, sorted_value, run_end, overflowed);
					error_count++;
				end
				if (sorted_q[0].run_end)
					runs_seen++;
				void'(sorted_q.pop_front());
			end
		end
	end

	initial begin : stimulus
		logic signed [VALUE_W-1:0] full_set [DEPTH] = '{
			VAL_MIN, VAL_MAX, 0, -1, 1, 7, -7, 7,
			VAL_MIN, VAL_MAX, 32'sh4000_0000, 32'shC000_0000, 2, -2, 0, 3
		};
		int  set_len;
		int  rand_count;
		bit  pause;

		// Single-value set at the top of the range
		queue_sample(VAL_MAX, 1'b1, 1'b0);
		// Fill the store with extremes and ties, then drop the set-end value
		foreach (full_set[i])
			queue_sample(full_set[i], 1'b0, 1'b0);
		queue_sample(5, 1'b1, 1'b0);
		// Equal values only, after the previous runs have drained
		queue_sample(32'sh1234_5678, 1'b0, 1'b1);
		queue_sample(32'sh1234_5678, 1'b0, 1'b0);
		queue_sample(32'sh1234_5678, 1'b1, 1'b0);

		// Random sets, mostly within the store size, some overflowing
		rand_count = 0;
		while (rand_count < RAND_ITEMS) begin
			set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 24)
				: $urandom_range(1, DEPTH);
			pause = (rand_count == 0) || ($urandom_range(0, 15) == 0);
			for (int k = 0; k < set_len; k++) begin
				queue_sample(pick_value(), k == set_len - 1, pause && k == 0);
				rand_count++;
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || sample_valid)
			@(posedge clk);
		while (sorted_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);

		$display("covered %0d input transfers in %0d sorted runs, %0d result transfers",
			items_taken, runs_seen, results_seen);
		$display("runs with dropped values: %0d, mismatches: %0d", overflow_runs, error_count);
		if (error_count == 0 && sorted_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
